>>> design/lkc_pkg.sv
// Shared types, sizes and command codes for the LRU key cache.
// Used by lkc_table, lkc_ctrl and lru_key_cache; depends on nothing.
package lkc_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int STAMP_BITS = 32;
  localparam int KEY_W      = 64;
  localparam int SRV_W      = 8;
  localparam int CMD_W      = 2;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [SRV_W-1:0]      srv_t;
  typedef logic [CMD_W-1:0]      cmd_t;

  localparam cmd_t CMD_LOOKUP = 2'd0;
  localparam cmd_t CMD_ADD    = 2'd1;
  localparam cmd_t CMD_UPDATE = 2'd2;
  localparam cmd_t CMD_REMOVE = 2'd3;

  localparam idx_t   IDX_LAST  = idx_t'(ENTRIES - 1);
  localparam stamp_t STAMP_MAX = '1;

  // registered read of one table entry
  typedef struct packed {
    logic   valid;
    key_t   key;
    srv_t   server;
    stamp_t stamp;
  } rd_t;

  // write-back of one table entry, with per-field enables
  typedef struct packed {
    logic   en;
    idx_t   idx;
    logic   valid;
    logic   key_en;
    key_t   key;
    logic   srv_en;
    srv_t   server;
    logic   stamp_en;
    stamp_t stamp;
  } wr_t;

  // command handed from the input side to the sequencer
  typedef struct packed {
    logic start;
    cmd_t command;
    key_t key;
    srv_t server;
  } req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic done;
    logic status;
    srv_t found;
  } res_t;

endpackage

>>> design/lkc_table.sv
// Entry storage for the LRU key cache: valid flops plus key, server and
// stamp arrays with one registered read port and one write port.
// Depends on lkc_pkg.
module lkc_table import lkc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  idx_t rd_idx,
  output rd_t  rd,
  input  wr_t  wr
);

  logic [ENTRIES-1:0] valid;
  key_t               key_mem   [ENTRIES];
  srv_t               srv_mem   [ENTRIES];
  stamp_t             stamp_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.idx] <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.key_en) begin
      key_mem[wr.idx] <= wr.key;
    end
    if (wr.en && wr.srv_en) begin
      srv_mem[wr.idx] <= wr.server;
    end
    if (wr.en && wr.stamp_en) begin
      stamp_mem[wr.idx] <= wr.stamp;
    end
    rd.key    <= key_mem[rd_idx];
    rd.server <= srv_mem[rd_idx];
    rd.stamp  <= stamp_mem[rd_idx];
    if (rst) begin
      rd.valid <= 1'b0;
    end else begin
      rd.valid <= valid[rd_idx];
    end
  end

endmodule

>>> design/lkc_ctrl.sv
// Scan sequencer for the LRU key cache: walks the table one entry a cycle
// through a shared key/stamp compare unit, then writes back at most one entry.
// Depends on lkc_pkg; drives lkc_table.
module lkc_ctrl import lkc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  output logic idle,
  output idx_t rd_idx,
  input  rd_t  rd,
  output wr_t  wr,
  input  logic res_ready,
  output res_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0] state;
  cmd_t       cmd_q;
  key_t       key_q;
  srv_t       srv_q;
  idx_t       cnt;
  logic       issue_done;
  logic       cmp_vld;
  idx_t       cmp_idx;
  logic       hit;
  idx_t       hit_idx;
  srv_t       hit_server;
  logic       free;
  idx_t       free_idx;
  idx_t       best_idx;
  stamp_t     best_stamp;
  stamp_t     use_clock;
  stamp_t     use_clock_next;
  logic       key_eq;
  logic       stamp_lt;
  logic       touch;
  logic       finish;

  assign idle   = (state == S_IDLE);
  assign rd_idx = cnt;
  assign finish = (state == S_WRITE) && res_ready;

  // shared compare unit
  assign key_eq   = rd.valid && (rd.key == key_q);
  assign stamp_lt = rd.stamp < best_stamp;

  assign use_clock_next = (use_clock == STAMP_MAX) ? use_clock : use_clock + 1'b1;
  assign touch = (cmd_q == CMD_ADD) || (hit && (cmd_q != CMD_REMOVE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      use_clock  <= '0;
      cmp_vld    <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      cmp_vld <= (state == S_SCAN) && !issue_done;
      cmp_idx <= cnt;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            cmd_q      <= req.command;
            key_q      <= req.key;
            srv_q      <= req.server;
            cnt        <= '0;
            issue_done <= 1'b0;
            hit        <= 1'b0;
            free       <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issue_done) begin
            cnt <= cnt + 1'b1;
            if (cnt == IDX_LAST) begin
              issue_done <= 1'b1;
            end
          end
          if (cmp_vld) begin
            if (!hit && key_eq) begin
              hit        <= 1'b1;
              hit_idx    <= cmp_idx;
              hit_server <= rd.server;
            end
            if (!free && !rd.valid) begin
              free     <= 1'b1;
              free_idx <= cmp_idx;
            end
            // strict compare keeps the lowest index on stamp ties
            if (cmp_idx == '0 || stamp_lt) begin
              best_idx   <= cmp_idx;
              best_stamp <= rd.stamp;
            end
            if (cmp_idx == IDX_LAST) begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (res_ready) begin
            if (touch) begin
              use_clock <= use_clock_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    wr          = '0;
    wr.idx      = hit_idx;
    wr.key      = key_q;
    wr.server   = srv_q;
    wr.stamp    = use_clock_next;
    wr.valid    = 1'b1;
    if (finish) begin
      unique case (cmd_q)
        CMD_ADD: begin
          wr.en       = 1'b1;
          wr.idx      = free ? free_idx : best_idx;
          wr.key_en   = 1'b1;
          wr.srv_en   = 1'b1;
          wr.stamp_en = 1'b1;
        end
        CMD_LOOKUP: begin
          wr.en       = hit;
          wr.stamp_en = 1'b1;
        end
        CMD_UPDATE: begin
          wr.en       = hit;
          wr.srv_en   = 1'b1;
          wr.stamp_en = 1'b1;
        end
        CMD_REMOVE: begin
          wr.en       = hit;
          wr.valid    = 1'b0;
          wr.stamp_en = 1'b1;
          wr.stamp    = '0;
        end
        default: wr.en = 1'b0;
      endcase
    end
  end

  always_comb begin
    res.done   = finish;
    res.status = (cmd_q != CMD_ADD) && !hit;
    res.found  = (cmd_q == CMD_LOOKUP && hit) ? hit_server : '0;
  end

`ifndef ASSERT_OFF
  a_write_in_wb: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> state == S_WRITE)
    else $error("table write outside write-back");

  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> !cmp_vld)
    else $error("write-back entered with compare pending");

  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || use_clock >= $past(use_clock))
    else $error("use clock moved backward");

  a_add_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (finish && cmd_q == CMD_ADD) |-> (wr.en && wr.valid))
    else $error("add did not write a valid entry");
`endif

endmodule

>>> design/lru_key_cache.sv
// Top level of the LRU key cache: input capture, output register and the
// table plus its scan sequencer. Depends on lkc_pkg, lkc_table, lkc_ctrl.
//
// A 16-entry fully associative table that maps a 64-bit key to an 8-bit
// server number with least-recently-used replacement. Commands are lookup,
// add, update and remove; each gives one result (status 0 success, 1 key
// not found; found_server set only on a lookup hit). Every command reads
// all ENTRIES entries in turn through the table's single read port, then
// writes back at most one entry. in_stall stays high while a command is in
// progress, so a new command is taken only once the previous one has
// written back. The write-back waits while the previous result is still
// stalled in the output register. The result sits in an output register,
// so a new command is taken while it waits. Reset clears all entries and
// the use clock.
module lru_key_cache import lkc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  cmd_t command,
  input  key_t key,
  input  srv_t server_number,
  output logic out_valid,
  input  logic out_stall,
  output logic status,
  output srv_t found_server
);

  req_t req;
  res_t res;
  rd_t  rd;
  wr_t  wr;
  idx_t rd_idx;
  logic idle;
  logic res_ready;

  assign in_stall  = !idle;
  assign res_ready = !out_valid || !out_stall;

  always_comb begin
    req.start   = in_valid && idle;
    req.command = command;
    req.key     = key;
    req.server  = server_number;
  end

  lkc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .idle      (idle),
    .rd_idx    (rd_idx),
    .rd        (rd),
    .wr        (wr),
    .res_ready (res_ready),
    .res       (res)
  );

  lkc_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      status       <= res.status;
      found_server <= res.found;
    end
  end

endmodule

>>> dv/lru_key_cache_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_cache: directed and random commands,
// predicted by an in-bench LRU table. Depends on lkc_pkg and the design.
module lru_key_cache_tb;
  import lkc_pkg::*;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_MISS   = 1'b1;
  localparam int POOL_SIZE   = 24;
  localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3);

  typedef struct packed {
    cmd_t command;
    key_t key;
    srv_t server;
  } cmd_item_t;

  typedef struct packed {
    logic status;
    srv_t found;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t command = CMD_LOOKUP;
  key_t key = '0;
  srv_t server_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic status;
  srv_t found_server;

  cmd_item_t cmd_q[$];
  reply_t    reply_q[$];
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        gap_left = 0;
  int        err_cnt = 0;

  // LRU table as the block should hold it
  logic   tbl_valid [ENTRIES];
  key_t   tbl_key   [ENTRIES];
  srv_t   tbl_srv   [ENTRIES];
  stamp_t tbl_stamp [ENTRIES];
  stamp_t use_count;
  key_t   key_pool  [POOL_SIZE];

  lru_key_cache dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .key          (key),
    .server_number(server_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found_server (found_server)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // saturating use clock
  function automatic stamp_t tick_use_count();
    if (use_count != STAMP_MAX) use_count = use_count + 1'b1;
    return use_count;
  endfunction

  function automatic reply_t predict_reply(cmd_item_t it);
    reply_t r;
    int idx;
    r.status = ST_OK;
    r.found = '0;
    idx = -1;
    if (it.command == CMD_ADD) begin
      for (int i = ENTRIES - 1; i >= 0; i--) if (!tbl_valid[i]) idx = i;
      if (idx < 0) begin
        // table full: oldest stamp, lowest index wins ties
        idx = 0;
        for (int i = 1; i < ENTRIES; i++) if (tbl_stamp[i] < tbl_stamp[idx]) idx = i;
      end
      tbl_valid[idx] = 1'b1;
      tbl_key[idx] = it.key;
      tbl_srv[idx] = it.server;
      tbl_stamp[idx] = tick_use_count();
    end else begin
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (tbl_valid[i] && tbl_key[i] == it.key) idx = i;
      if (idx < 0) begin
        r.status = ST_MISS;
      end else begin
        case (it.command)
          CMD_LOOKUP: begin
            tbl_stamp[idx] = tick_use_count();
            r.found = tbl_srv[idx];
          end
          CMD_UPDATE: begin
            tbl_srv[idx] = it.server;
            tbl_stamp[idx] = tick_use_count();
          end
          default: begin
            tbl_valid[idx] = 1'b0;
            tbl_stamp[idx] = '0;
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    err_cnt++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
  endtask

  task automatic queue_cmd(cmd_t c, key_t k, srv_t s);
    cmd_item_t it;
    it.command = c;
    it.key = k;
    it.server = s;
    cmd_q.push_back(it);
  endtask

  // sender: new transfer offered at the falling edge once the last one went
  always @(negedge clk) begin
    cmd_item_t cur;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = cmd_q.pop_front();
          in_valid <= 1'b1;
          command <= cur.command;
          key <= cur.key;
          server_number <= cur.server;
        end else begin
          in_valid <= 1'b0;
          // idle stretches of varied length land on every cycle of a command
          if (send_idle_pct != 0) gap_left <= $urandom_range(0, 24);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // receiver check and prediction, at the rising edge
  always @(posedge clk) begin
    reply_t want;
    cmd_item_t seen;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          flag_mismatch("unexpected result (none pending), status/found_server",
                        64'hx, 64'({status, found_server}));
        end else begin
          want = reply_q.pop_front();
          if (status !== want.status)
            flag_mismatch("status", 64'(want.status), 64'(status));
          if (found_server !== want.found)
            flag_mismatch("found_server", 64'(want.found), 64'(found_server));
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen.command = command;
        seen.key = key;
        seen.server = server_number;
        reply_q.push_back(predict_reply(seen));
      end
    end
  end

  initial begin
    int idle_pcts [4];
    int stall_pcts [4];
    int phase_len [4];
    cmd_item_t it;
    int pick;
    idle_pcts = '{0, 68, 0, 25};
    stall_pcts = '{0, 0, 68, 25};
    phase_len = '{450, 450, 450, 400};
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_srv[i] = '0;
      tbl_stamp[i] = '0;
    end
    use_count = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'hAAAA_AAAA_AAAA_AAAA;
    key_pool[3] = 64'h5555_5555_5555_5555;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: misses on an empty table, extremes, duplicates, ignored fields
    queue_cmd(CMD_LOOKUP, '0, 8'h00);
    queue_cmd(CMD_UPDATE, '1, 8'h11);
    queue_cmd(CMD_REMOVE, '0, 8'h00);
    queue_cmd(CMD_ADD,    '0, 8'h00);
    queue_cmd(CMD_ADD,    '1, 8'hFF);
    queue_cmd(CMD_LOOKUP, '0, 8'h00);
    queue_cmd(CMD_LOOKUP, '1, 8'h00);
    queue_cmd(CMD_UPDATE, '1, 8'hA5);
    queue_cmd(CMD_LOOKUP, '1, 8'h00);
    queue_cmd(CMD_ADD,    64'h5A5A_5A5A_5A5A_5A5A, 8'h01);
    queue_cmd(CMD_ADD,    64'h5A5A_5A5A_5A5A_5A5A, 8'h02);
    queue_cmd(CMD_LOOKUP, 64'h5A5A_5A5A_5A5A_5A5A, 8'h00);
    queue_cmd(CMD_UPDATE, 64'h5A5A_5A5A_5A5A_5A5A, 8'h03);
    queue_cmd(CMD_REMOVE, 64'h5A5A_5A5A_5A5A_5A5A, 8'h00);
    queue_cmd(CMD_LOOKUP, 64'h5A5A_5A5A_5A5A_5A5A, 8'h00);
    queue_cmd(CMD_REMOVE, '1, 8'h00);
    queue_cmd(CMD_LOOKUP, '1, 8'h00);
    queue_cmd(CMD_ADD,    64'h8000_0000_0000_0001, 8'h80);
    queue_cmd(CMD_LOOKUP, 64'h8000_0000_0000_0001, 8'h7F);
    queue_cmd(CMD_REMOVE, 64'h8000_0000_0000_0001, 8'hFF);
    queue_cmd(CMD_LOOKUP, 64'h8000_0000_0000_0001, 8'h00);

    // random: keys mostly from a pool larger than the table, so hits,
    // misses, duplicates and evictions all occur
    for (int p = 0; p < 4; p++) begin
      while (cmd_q.size() != 0 || in_valid) @(posedge clk);
      send_idle_pct = idle_pcts[p];
      stall_pct = stall_pcts[p];
      for (int n = 0; n < phase_len[p]; n++) begin
        pick = $urandom_range(99);
        if (pick < 35) it.command = CMD_ADD;
        else if (pick < 65) it.command = CMD_LOOKUP;
        else if (pick < 80) it.command = CMD_UPDATE;
        else it.command = CMD_REMOVE;
        if ($urandom_range(99) < 3)
          key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
        if ($urandom_range(99) < 90) it.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else it.key = {$urandom, $urandom};
        it.server = srv_t'($urandom_range(255));
        cmd_q.push_back(it);
      end
    end

    while (cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: a correct run needs well under a tenth of this
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> lru_key_cache.f
design/lkc_pkg.sv
design/lkc_table.sv
design/lkc_ctrl.sv
design/lru_key_cache.sv
dv/lru_key_cache_tb.sv
